// File: src/mvm_pkg.sv
// ----------------------------------------------------------------------------
// mvm_pkg
// Shared types and constants for the streamed matrix-vector product.
// ----------------------------------------------------------------------------
package mvm_pkg;

    localparam int DEF_MAX_COLS = 256;
    localparam int DEF_MAX_ROWS = 1024;

    localparam int VAL_W   = 16;   // Q8.8 element
    localparam int PROD_W  = 32;   // Q16.16 product
    localparam int SUM_W   = 40;   // Q24.16 accumulator
    localparam int IDX_W   = 10;   // row index on the result
    localparam int ROWC_W  = 11;   // row_count register
    localparam int COLC_W  = 9;    // col_count register
    localparam int CFGD_W  = 11;   // widest register
    localparam int OUTD_W  = 56;   // row_sum and row_index, padded to bytes
    localparam int QUEUE_DEPTH = 4;

    // Register indexes.
    localparam logic REG_ROW_COUNT = 1'b0;
    localparam logic REG_COL_COUNT = 1'b1;

    // Input kinds.
    localparam logic KIND_VECTOR = 1'b0;
    localparam logic KIND_MATRIX = 1'b1;

    // One multiply-accumulate operation handed from the front to the back.
    typedef struct packed {
        logic signed [VAL_W-1:0] a;
        logic signed [VAL_W-1:0] b;
        logic                    first;
        logic                    end_row;
        logic                    last;
        logic [IDX_W-1:0]        row_idx;
    } t_op;

endpackage

// File: src/mvm_queue.sv
// ----------------------------------------------------------------------------
// mvm_queue
// Short first-in first-out queue of operations between front and back.
// ----------------------------------------------------------------------------
module mvm_queue (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  mvm_pkg::t_op i_op,
    output logic         o_full,
    input  logic         i_pop,
    output logic         o_valid,
    output mvm_pkg::t_op o_op
);

    localparam int PW = $clog2(mvm_pkg::QUEUE_DEPTH);
    localparam int CW = $clog2(mvm_pkg::QUEUE_DEPTH + 1);

    mvm_pkg::t_op r_mem [mvm_pkg::QUEUE_DEPTH];
    logic [PW-1:0] r_wr, n_wr;
    logic [PW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_cnt, n_cnt;

    assign o_full  = (r_cnt == CW'(mvm_pkg::QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_op    = r_mem[r_rd];

    always_comb begin
        n_wr  = i_push ? r_wr + PW'(1) : r_wr;
        n_rd  = i_pop  ? r_rd + PW'(1) : r_rd;
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + CW'(1);
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_op;
        end
    end

endmodule

// File: src/mvm_front.sv
// ----------------------------------------------------------------------------
// mvm_front
// Accepts input items, keeps the vector store and the column and row
// positions, and issues one operation per matrix element to the queue.
// ----------------------------------------------------------------------------
module mvm_front #(
    parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_ready,
    input  logic                              i_kind,
    input  logic signed [mvm_pkg::VAL_W-1:0]  i_value,
    input  logic [$clog2(MAX_COLS+1)-1:0]     i_col_lim,
    input  logic [$clog2(MAX_ROWS+1)-1:0]     i_row_lim,
    output logic                              o_push,
    output mvm_pkg::t_op                      o_op,
    input  logic                              i_q_full
);

    localparam int AW  = $clog2(MAX_COLS);
    localparam int FW  = $clog2(MAX_COLS + 1);
    localparam int RPW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

    logic signed [mvm_pkg::VAL_W-1:0] r_store [MAX_COLS];

    logic [FW-1:0]  r_fill, n_fill;
    logic [AW-1:0]  r_col, n_col;
    logic [RPW-1:0] r_row, n_row;
    logic           r_s1_valid, n_s1_valid;
    mvm_pkg::t_op   r_s1_op;
    logic signed [mvm_pkg::VAL_W-1:0] r_s1_b;

    logic          accept;
    logic          acc_vec;
    logic          acc_mat;
    logic [FW-1:0] fill_idx;
    logic          end_row;
    logic          last_row;
    logic [31:0]   row_wide;

    assign o_ready  = !r_s1_valid || !i_q_full;
    assign accept   = i_valid && o_ready;
    assign acc_vec  = accept && (i_kind == mvm_pkg::KIND_VECTOR);
    assign acc_mat  = accept && (i_kind == mvm_pkg::KIND_MATRIX);
    assign o_push   = r_s1_valid && !i_q_full;

    // A full store starts the next vector from the first entry.
    assign fill_idx = (r_fill >= i_col_lim) ? '0 : r_fill;
    assign end_row  = (32'(r_col) + 32'd1 >= 32'(i_col_lim));
    assign last_row = (32'(r_row) + 32'd1 >= 32'(i_row_lim));
    assign row_wide = 32'(r_row);

    always_comb begin
        o_op   = r_s1_op;
        o_op.b = r_s1_b;
    end

    always_comb begin
        n_fill     = r_fill;
        n_col      = r_col;
        n_row      = r_row;
        n_s1_valid = o_push ? 1'b0 : r_s1_valid;
        if (acc_vec) begin
            n_fill = fill_idx + FW'(1);
            n_col  = '0;
            n_row  = '0;
        end else if (acc_mat) begin
            n_s1_valid = 1'b1;
            if (end_row) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + RPW'(1);
            end else begin
                n_col = r_col + AW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill     <= '0;
            r_col      <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            r_fill     <= n_fill;
            r_col      <= n_col;
            r_row      <= n_row;
            r_s1_valid <= n_s1_valid;
        end
    end

    // Vector store, one write or one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (acc_vec) begin
            r_store[fill_idx[AW-1:0]] <= i_value;
        end
        if (acc_mat) begin
            r_s1_b <= r_store[r_col];
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc_mat) begin
            r_s1_op.a       <= i_value;
            r_s1_op.b       <= '0;
            r_s1_op.first   <= (r_col == '0);
            r_s1_op.end_row <= end_row;
            r_s1_op.last    <= last_row;
            r_s1_op.row_idx <= row_wide[mvm_pkg::IDX_W-1:0];
        end
    end

endmodule

// File: src/mvm_back.sv
// ----------------------------------------------------------------------------
// mvm_back
// Multiplies, accumulates the row sum and holds each finished row in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module mvm_back (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_q_valid,
    input  mvm_pkg::t_op                        i_op,
    output logic                                o_pop,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic signed [mvm_pkg::SUM_W-1:0]    o_sum,
    output logic [mvm_pkg::IDX_W-1:0]           o_idx,
    output logic                                o_last
);

    logic                               adv;
    logic                               r_m_valid;
    logic signed [mvm_pkg::PROD_W-1:0]  r_prod;
    logic                               r_m_first;
    logic                               r_m_end;
    logic                               r_m_last;
    logic [mvm_pkg::IDX_W-1:0]          r_m_idx;
    logic signed [mvm_pkg::SUM_W-1:0]   r_acc;
    logic signed [mvm_pkg::SUM_W-1:0]   sum_next;
    logic                               r_out_valid, n_out_valid;
    logic                               load_out;

    assign adv      = !r_out_valid || i_ready;
    assign o_pop    = i_q_valid && adv;
    assign load_out = adv && r_m_valid && r_m_end;

    // The first column of a row starts the sum afresh.
    assign sum_next = (r_m_first ? '0 : r_acc)
                    + {{(mvm_pkg::SUM_W - mvm_pkg::PROD_W){r_prod[mvm_pkg::PROD_W-1]}},
                       r_prod};

    always_comb begin
        n_out_valid = r_out_valid;
        if (load_out) begin
            n_out_valid = 1'b1;
        end else if (i_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_m_valid <= o_pop;
            end
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prod    <= i_op.a * i_op.b;
            r_m_first <= i_op.first;
            r_m_end   <= i_op.end_row;
            r_m_last  <= i_op.last;
            r_m_idx   <= i_op.row_idx;
        end
        if (adv && r_m_valid) begin
            r_acc <= sum_next;
        end
        if (load_out) begin
            o_sum  <= sum_next;
            o_idx  <= r_m_idx;
            o_last <= r_m_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

// File: src/matrix_vector_multiply.sv
// ----------------------------------------------------------------------------
// matrix_vector_multiply
// The last element of a row passes through the front register, the queue and the
// product register before its row sum is loaded into the output register.
// Throughput: one element per cycle while the output is not held back, set by the single multiply-accumulate.
// The vector store is read once per matrix element, written once per vector one.
// Reset clears positions, queue and valid flags; registers return to one.
// The vector store needs no clearing pass; items are taken right after reset.
// ----------------------------------------------------------------------------
module matrix_vector_multiply #(
    parameter int MAX_COLS = mvm_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = mvm_pkg::DEF_MAX_ROWS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_idx,
    input  logic [mvm_pkg::CFGD_W-1:0]    i_cfg_data,
    input  logic                          i_s_tvalid,
    output logic                          o_s_tready,
    input  logic [mvm_pkg::VAL_W-1:0]     i_s_tdata,  // [15:0] value
    input  logic                          i_s_tuser,  // [0] kind
    output logic                          o_m_tvalid,
    input  logic                          i_m_tready,
    output logic [mvm_pkg::OUTD_W-1:0]    o_m_tdata,  // [39:0] row_sum, [49:40] row_index
    output logic                          o_m_tlast   // last_row
);

    localparam int FW = $clog2(MAX_COLS + 1);
    localparam int RW = $clog2(MAX_ROWS + 1);

    logic [FW-1:0] r_col_lim;
    logic [RW-1:0] r_row_lim;
    logic [31:0]   row_req;
    logic [31:0]   col_req;
    logic [31:0]   row_lim_w;
    logic [31:0]   col_lim_w;

    logic          push;
    logic          q_full;
    logic          q_valid;
    logic          pop;
    mvm_pkg::t_op  push_op;
    mvm_pkg::t_op  head_op;

    logic signed [mvm_pkg::SUM_W-1:0] out_sum;
    logic [mvm_pkg::IDX_W-1:0]        out_idx;

    // The counts are held already limited to their legal ranges.
    assign row_req   = 32'(i_cfg_data[mvm_pkg::ROWC_W-1:0]);
    assign col_req   = 32'(i_cfg_data[mvm_pkg::COLC_W-1:0]);
    assign row_lim_w = (row_req == 32'd0) ? 32'd1 :
                       (row_req > 32'(MAX_ROWS)) ? 32'(MAX_ROWS) : row_req;
    assign col_lim_w = (col_req == 32'd0) ? 32'd1 :
                       (col_req > 32'(MAX_COLS)) ? 32'(MAX_COLS) : col_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_lim <= RW'(1);
            r_col_lim <= FW'(1);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                mvm_pkg::REG_ROW_COUNT: r_row_lim <= row_lim_w[RW-1:0];
                mvm_pkg::REG_COL_COUNT: r_col_lim <= col_lim_w[FW-1:0];
                default: ;
            endcase
        end
    end

    mvm_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_kind    (i_s_tuser),
        .i_value   (i_s_tdata),
        .i_col_lim (r_col_lim),
        .i_row_lim (r_row_lim),
        .o_push    (push),
        .o_op      (push_op),
        .i_q_full  (q_full)
    );

    mvm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_op    (head_op)
    );

    mvm_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_op      (head_op),
        .o_pop     (pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_sum     (out_sum),
        .o_idx     (out_idx),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {
        {(mvm_pkg::OUTD_W - mvm_pkg::SUM_W - mvm_pkg::IDX_W){1'b0}},
        out_idx,
        out_sum
    };

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the streamed matrix-vector product. Vector and
// matrix elements are sent over the input stream with random gaps, and the
// row sums are checked against a bit-exact software copy of the datapath.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int MAX_COLS    = mvm_pkg::DEF_MAX_COLS;
    localparam int MAX_ROWS    = mvm_pkg::DEF_MAX_ROWS;
    localparam int CYCLE_CAP   = 500000;
    localparam int DRAIN_WAIT  = 8;
    localparam int HOLD_LEN    = 200;
    localparam int ITEM_TARGET = 950;
    localparam int FINAL_ITEMS = 2 * MAX_COLS;

    typedef struct {
        logic                      kind;
        logic [mvm_pkg::VAL_W-1:0] value;
    } t_elem;

    typedef struct {
        logic signed [mvm_pkg::SUM_W-1:0] row_sum;
        logic [mvm_pkg::IDX_W-1:0]        row_index;
        logic                             last_row;
    } t_row_result;

    logic                       i_clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_we = 1'b0;
    logic                       cfg_idx = mvm_pkg::REG_ROW_COUNT;
    logic [mvm_pkg::CFGD_W-1:0] cfg_data = '0;
    logic                       s_tvalid = 1'b0;
    logic                       s_tready;
    logic [mvm_pkg::VAL_W-1:0]  s_tdata = '0;
    logic                       s_tuser = mvm_pkg::KIND_VECTOR;
    logic                       m_tvalid;
    logic                       m_tready = 1'b0;
    logic [mvm_pkg::OUTD_W-1:0] m_tdata;
    logic                       m_tlast;

    matrix_vector_multiply u_top (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),   // [15:0] value
        .i_s_tuser  (s_tuser),   // [0] kind
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata),   // [39:0] row_sum, [49:40] row_index
        .o_m_tlast  (m_tlast)    // last_row
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // Register copies shared by the generator and the row-sum predictor.
    logic [mvm_pkg::ROWC_W-1:0] cfg_rows = 11'd1;
    logic [mvm_pkg::COLC_W-1:0] cfg_cols = 9'd1;

    // Predictor state.
    logic signed [mvm_pkg::VAL_W-1:0] vec_store [MAX_COLS];
    int                               vec_fill = 0;
    int                               col_pos = 0;
    int                               row_pos = 0;
    logic signed [mvm_pkg::SUM_W-1:0] row_acc = '0;

    // Generator tracking, used only to keep matrix reads on written entries.
    bit gen_written [MAX_COLS];
    int gen_fill = 0;
    int gen_col = 0;

    t_elem       pending_elems [$];
    t_row_result expected_rows [$];
    t_elem       cur_elem = '{mvm_pkg::KIND_VECTOR, '0};

    int error_count = 0;
    int mismatch_count = 0;
    int queued_items = 0;
    int cycle_count = 0;
    int gap_left = 0;
    int stall_left = 0;
    int hold_left = 0;
    bit idle_off = 1'b0;
    bit long_hold_arm = 1'b0;
    bit long_hold_done = 1'b0;

    function automatic int eff_cols();
        if (cfg_cols == 0) return 1;
        if (cfg_cols > MAX_COLS) return MAX_COLS;
        return int'(cfg_cols);
    endfunction

    function automatic int eff_rows();
        if (cfg_rows == 0) return 1;
        if (cfg_rows > MAX_ROWS) return MAX_ROWS;
        return int'(cfg_rows);
    endfunction

    // Applies one accepted element and queues the row sum it completes, if any.
    task automatic accumulate_element(input t_elem e);
        int n;
        int m;
        logic signed [mvm_pkg::PROD_W-1:0] prod;
        t_row_result r;
        n = eff_cols();
        m = eff_rows();
        if (e.kind == mvm_pkg::KIND_VECTOR) begin
            if (vec_fill >= n) vec_fill = 0;
            vec_store[vec_fill % MAX_COLS] = e.value;
            vec_fill++;
            col_pos = 0;
            row_pos = 0;
            row_acc = '0;
        end else begin
            prod = $signed(e.value) * vec_store[col_pos % MAX_COLS];
            row_acc = row_acc + prod;
            if (col_pos + 1 >= n) begin
                r.row_sum = row_acc;
                r.row_index = row_pos[mvm_pkg::IDX_W-1:0];
                r.last_row = (row_pos + 1 >= m);
                expected_rows.push_back(r);
                row_acc = '0;
                col_pos = 0;
                row_pos = r.last_row ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        end
    endtask

    // A matrix element whose column has never been loaded is sent as a vector
    // element instead, so the store is never read before it is written.
    task automatic queue_element(input logic kind, input logic [mvm_pkg::VAL_W-1:0] value);
        int n;
        t_elem e;
        n = eff_cols();
        e.kind = kind;
        e.value = value;
        if (kind == mvm_pkg::KIND_MATRIX && !gen_written[gen_col % MAX_COLS])
            e.kind = mvm_pkg::KIND_VECTOR;
        if (e.kind == mvm_pkg::KIND_VECTOR) begin
            if (gen_fill >= n) gen_fill = 0;
            gen_written[gen_fill % MAX_COLS] = 1'b1;
            gen_fill++;
            gen_col = 0;
        end else begin
            gen_col = (gen_col + 1 >= n) ? 0 : gen_col + 1;
        end
        pending_elems.push_back(e);
        queued_items++;
    endtask

    function automatic logic [mvm_pkg::VAL_W-1:0] pick_value();
        case ($urandom_range(0, 7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            3: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [mvm_pkg::CFGD_W-1:0] pick_rows();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 11'($urandom_range(7, 16));
            default: return 11'($urandom_range(1, 6));
        endcase
    endfunction

    function automatic logic [mvm_pkg::CFGD_W-1:0] pick_cols();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return 11'($urandom_range(9, 24));
            default: return 11'($urandom_range(1, 8));
        endcase
    endfunction

    // Waits until every element has gone in and every row sum has come out,
    // then lets the pipeline empty of elements that complete no row.
    task automatic wait_drained();
        do @(negedge i_clk);
        while (pending_elems.size() != 0 || s_tvalid || expected_rows.size() != 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic idx, input logic [mvm_pkg::CFGD_W-1:0] data);
        @(posedge i_clk);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        if (idx == mvm_pkg::REG_ROW_COUNT) cfg_rows = data;
        else cfg_cols = data[mvm_pkg::COLC_W-1:0];
        @(negedge i_clk);
    endtask

    task automatic random_phase();
        int n;
        int m;
        int reps;
        int count;
        int pick;
        wait_drained();
        pick = $urandom_range(0, 3);
        if (pick != 1) write_reg(mvm_pkg::REG_ROW_COUNT, pick_rows());
        if (pick != 2) write_reg(mvm_pkg::REG_COL_COUNT, pick_cols());
        n = eff_cols();
        m = eff_rows();
        count = 0;
        if ($urandom_range(0, 4) != 0) begin
            for (int i = 0; i < n; i++) begin
                queue_element(mvm_pkg::KIND_VECTOR, pick_value());
                count++;
                if ($urandom_range(0, 39) == 0) break;
            end
            reps = (m * n > 40) ? 1 : $urandom_range(1, 3);
            for (int i = 0; i < reps * m * n; i++) begin
                if ($urandom_range(0, 59) == 0) begin
                    queue_element(mvm_pkg::KIND_VECTOR, pick_value());
                    count++;
                end
                queue_element(mvm_pkg::KIND_MATRIX, pick_value());
                count++;
            end
        end else begin
            repeat ($urandom_range(5, 20)) begin
                queue_element($urandom_range(0, 1) ? mvm_pkg::KIND_MATRIX :
                              mvm_pkg::KIND_VECTOR, pick_value());
                count++;
            end
        end
        if (count >= 40) long_hold_arm = 1'b1;
    endtask

    // Input side: one element on the bus at a time, random gaps between them while idle_off is clear.
    always @(posedge i_clk) begin
        logic offering;
        if (!rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            offering = s_tvalid;
            if (s_tvalid && s_tready) begin
                accumulate_element(cur_elem);
                offering = 1'b0;
            end
            if (!offering) begin
                if (gap_left > 0) begin
                    gap_left--;
                end else if (!idle_off && pending_elems.size() != 0 &&
                             $urandom_range(0, 11) == 0) begin
                    gap_left = $urandom_range(0, 17);
                end else if (pending_elems.size() != 0) begin
                    cur_elem = pending_elems.pop_front();
                    offering = 1'b1;
                end
            end
            s_tvalid <= offering;
            s_tdata <= cur_elem.value;
            s_tuser <= cur_elem.kind;
        end
    end

    // Output side: checks each transaction and drives back-pressure.
    always @(posedge i_clk) begin
        t_row_result want;
        logic ready_next;
        if (!rst_n) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_rows.size() == 0) begin
                    error_count++;
                    if (mismatch_count < 10)
                        $display("unexpected row sum %0d for row %0d",
                                 $signed(m_tdata[mvm_pkg::SUM_W-1:0]),
                                 m_tdata[mvm_pkg::SUM_W+mvm_pkg::IDX_W-1:mvm_pkg::SUM_W]);
                    mismatch_count++;
                end else begin
                    want = expected_rows.pop_front();
                    if (m_tdata[mvm_pkg::SUM_W-1:0] !== want.row_sum ||
                        m_tdata[mvm_pkg::SUM_W+mvm_pkg::IDX_W-1:mvm_pkg::SUM_W]
                            !== want.row_index ||
                        m_tlast !== want.last_row) begin
                        error_count++;
                        if (mismatch_count < 10)
                            $display("row sum mismatch: sum %0d/%0d index %0d/%0d last %0b/%0b",
                                     want.row_sum, $signed(m_tdata[mvm_pkg::SUM_W-1:0]),
                                     want.row_index,
                                     m_tdata[mvm_pkg::SUM_W+mvm_pkg::IDX_W-1:mvm_pkg::SUM_W],
                                     want.last_row, m_tlast);
                        mismatch_count++;
                    end
                end
            end
            if (long_hold_arm && !long_hold_done) begin
                hold_left = HOLD_LEN;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                ready_next = 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if (!idle_off && $urandom_range(0, 11) == 0) begin
                stall_left = $urandom_range(0, 17);
                ready_next = 1'b0;
            end else begin
                ready_next = 1'b1;
            end
            m_tready <= ready_next;
        end
    end

    initial begin
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[matrix_vector_multiply] ERROR");
        $finish;
    end

    initial begin
        repeat (6) @(posedge i_clk);
        rst_n <= 1'b1;
        @(negedge i_clk);

        // With the reset settings every matrix element is a whole, final row.
        queue_element(mvm_pkg::KIND_VECTOR, 16'd7);
        queue_element(mvm_pkg::KIND_MATRIX, 16'hFFFD);
        wait_drained();
        write_reg(mvm_pkg::REG_ROW_COUNT, 11'd2);
        write_reg(mvm_pkg::REG_COL_COUNT, 11'd4);
        queue_element(mvm_pkg::KIND_VECTOR, 16'h7FFF);
        queue_element(mvm_pkg::KIND_VECTOR, 16'h8000);
        queue_element(mvm_pkg::KIND_VECTOR, 16'h0000);
        queue_element(mvm_pkg::KIND_VECTOR, 16'h0001);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h8000);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h8000);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h7FFF);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h0005);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h7FFF);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h7FFF);
        queue_element(mvm_pkg::KIND_MATRIX, 16'hFFFF);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h8000);
        // A second matrix reuses the same vector, starting again at row zero.
        queue_element(mvm_pkg::KIND_MATRIX, 16'h0001);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h0002);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h0003);
        queue_element(mvm_pkg::KIND_MATRIX, 16'h0004);
        // A full vector wraps to index zero; the old entries stay in use.
        queue_element(mvm_pkg::KIND_VECTOR, 16'd100);
        repeat (4) queue_element(mvm_pkg::KIND_MATRIX, pick_value());
        // A vector element part-way through a row restarts the product.
        repeat (2) queue_element(mvm_pkg::KIND_MATRIX, pick_value());
        queue_element(mvm_pkg::KIND_VECTOR, 16'hFFFF);
        // The output is held off while these elements are still being offered.
        long_hold_arm = 1'b1;

        while (queued_items < ITEM_TARGET - FINAL_ITEMS) random_phase();

        // Widest row with extreme values: the largest row sum.
        idle_off = 1'b1;
        wait_drained();
        write_reg(mvm_pkg::REG_COL_COUNT, 11'd511);
        write_reg(mvm_pkg::REG_ROW_COUNT, 11'd1);
        repeat (MAX_COLS) queue_element(mvm_pkg::KIND_VECTOR, 16'h8000);
        repeat (MAX_COLS) queue_element(mvm_pkg::KIND_MATRIX, 16'h8000);

        wait_drained();
        repeat (10) @(posedge i_clk);
        if (error_count == 0 && expected_rows.size() == 0) begin
            $display("[matrix_vector_multiply] OK");
        end else begin
            $display("[matrix_vector_multiply] ERROR");
        end
        $finish;
    end

endmodule
